// ===== rtl/core/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types, codes and helpers for the polymorphic register file access
// block: item layouts, controller/datapath handshake and small divide helper.
// ----------------------------------------------------------------------------
package pra_pkg;

  // Default geometry
  localparam int DEF_MOD_ROWS     = 2;
  localparam int DEF_MOD_COLS     = 4;
  localparam int DEF_MATRIX_COLS  = 64;
  localparam int DEF_MODULE_DEPTH = 512;

  // Fixed field widths
  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int SLOT_W   = 9;
  localparam int SCHEME_W = 3;
  localparam int MODIX_W  = 3;

  // Reciprocal-multiply divide: estimate = (value * (2^SHIFT / d)) >> SHIFT, then corrected once
  localparam int RECIP_SHIFT = 8;
  localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

  // Operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_PREAD  = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SCHEME = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // Module-assignment schemes
  localparam logic [SCHEME_W-1:0] SCH_NONE       = 3'd0;
  localparam logic [SCHEME_W-1:0] SCH_RECT       = 3'd1;
  localparam logic [SCHEME_W-1:0] SCH_RECT_ROW   = 3'd2;
  localparam logic [SCHEME_W-1:0] SCH_RECT_COL   = 3'd3;
  localparam logic [SCHEME_W-1:0] SCH_ROW_COL    = 3'd4;
  localparam logic [SCHEME_W-1:0] SCH_RECT_TRECT = 3'd5;

  // Input word
  typedef struct packed {
    logic [1:0]                op;
    logic [INDEX_W-1:0]        row_index;
    logic [INDEX_W-1:0]        col_index;
    logic signed [WORD_W-1:0]  write_data;
    logic [SLOT_W-1:0]         slot;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic signed [WORD_W-1:0]  read_data;
    logic [MODIX_W-1:0]        module_row;
    logic [MODIX_W-1:0]        module_col;
    logic [1:0]                status;
    logic                      last;
  } out_item_t;

  // Which result the datapath builds
  typedef enum logic [2:0] {
    EK_NOSCH,
    EK_RANGE,
    EK_WRITE,
    EK_READ,
    EK_PAR
  } emit_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    emit_kind_t kind;
    logic       mem_wr;
    logic       mem_rd;
    logic       rd_par;
    logic       par_init;
    logic       par_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       scheme_ok;
    logic       slot_ok;
    logic       addr_ok;
    logic       par_last;
  } stat_t;

  // Quotient and remainder of a small divide
  typedef struct packed {
    logic [6:0] quot;
    logic [2:0] rem;
  } dm_t;

  // Divide a 7-bit value by a divisor of 1..8 using its precomputed reciprocal
  function automatic dm_t divmod_small(logic [6:0] value, logic [3:0] divisor,
                                       logic [8:0] recip);
    logic [15:0] prod;
    logic [6:0]  q0;
    logic [10:0] qd;
    logic [6:0]  r0;
    dm_t         res;
    prod = 16'(value) * 16'(recip);
    q0   = 7'(prod >> RECIP_SHIFT);
    qd   = 11'(q0) * 11'(divisor);
    r0   = value - qd[6:0];
    // estimate may be one short: correct once
    if (r0 >= 7'(divisor)) begin
      res.quot = q0 + 7'd1;
      res.rem  = 3'(r0 - 7'(divisor));
    end else begin
      res.quot = q0;
      res.rem  = r0[2:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pra_ctrl.sv =====
// ----------------------------------------------------------------------------
// pra_ctrl
// Sequencer: steps each accepted word through mapping, memory access and
// result strobe, and walks the module grid on a parallel read.
// ----------------------------------------------------------------------------
module pra_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pra_pkg::stat_t stat,
  output pra_pkg::cmd_t  cmd,
  output logic           busy
);
  import pra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MAP,
    S_FLAT,
    S_ACCESS,
    S_RDOUT,
    S_PRD,
    S_PEMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = EK_NOSCH;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_PREAD: begin
            if (stat.slot_ok) begin
              cmd.par_init = 1'b1;
              state_nxt    = S_PRD;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = EK_RANGE;
              state_nxt = S_IDLE;
            end
          end
          OP_WRITE, OP_READ: begin
            if (stat.scheme_ok) begin
              state_nxt = S_MAP;
            end else begin
              cmd.emit  = 1'b1;
              cmd.kind  = EK_NOSCH;
              state_nxt = S_IDLE;
            end
          end
          OP_IGNORE: begin
            state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MAP: begin
        state_nxt = S_FLAT;
      end
      S_FLAT: begin
        if (stat.addr_ok) begin
          state_nxt = S_ACCESS;
        end else begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_RANGE;
          state_nxt = S_IDLE;
        end
      end
      S_ACCESS: begin
        if (stat.op == OP_WRITE) begin
          cmd.mem_wr = 1'b1;
          cmd.emit   = 1'b1;
          cmd.kind   = EK_WRITE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_RDOUT;
        end
      end
      S_RDOUT: begin
        cmd.emit  = 1'b1;
        cmd.kind  = EK_READ;
        state_nxt = S_IDLE;
      end
      S_PRD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_par = 1'b1;
        state_nxt  = S_PEMIT;
      end
      S_PEMIT: begin
        cmd.emit     = 1'b1;
        cmd.kind     = EK_PAR;
        cmd.par_step = 1'b1;
        state_nxt    = stat.par_last ? S_IDLE : S_PRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // Hold state and busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== rtl/core/pra_dp.sv =====
// ----------------------------------------------------------------------------
// pra_dp
// Datapath: scheme register, two-stage module mapping, flat address, word
// memory, parallel-read walker and the result register.
// ----------------------------------------------------------------------------
module pra_dp #(
  parameter int MOD_ROWS     = pra_pkg::DEF_MOD_ROWS,
  parameter int MOD_COLS     = pra_pkg::DEF_MOD_COLS,
  parameter int MATRIX_COLS  = pra_pkg::DEF_MATRIX_COLS,
  parameter int MODULE_DEPTH = pra_pkg::DEF_MODULE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pra_pkg::cmd_t                    cmd,
  output pra_pkg::stat_t                   stat,
  input  pra_pkg::in_item_t                in_item,
  input  logic                             cfg_we,
  input  logic [pra_pkg::SCHEME_W-1:0]     cfg_data,
  output logic                             out_valid,
  output pra_pkg::out_item_t               out_item
);
  import pra_pkg::*;

  localparam int NUM_WORDS   = MOD_ROWS * MOD_COLS * MODULE_DEPTH;
  localparam int FLAT_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ROW_STRIDE  = MATRIX_COLS / MOD_COLS;
  localparam int LA_MAX      = (63 / MOD_ROWS) * ROW_STRIDE + 63 / MOD_COLS;
  localparam int LA_W        = (LA_MAX > 0) ? $clog2(LA_MAX + 1) : 1;
  localparam int DEPTH_W     = $clog2(MODULE_DEPTH + 1);
  localparam int ACMP_W      = (LA_W > DEPTH_W) ? LA_W : DEPTH_W;
  localparam int SCMP_W      = (SLOT_W > DEPTH_W) ? SLOT_W : DEPTH_W;
  localparam logic [3:0] DIV_P   = 4'(MOD_ROWS);
  localparam logic [3:0] DIV_Q   = 4'(MOD_COLS);
  localparam logic [8:0] RECIP_P = 9'(RECIP_ONE / MOD_ROWS);
  localparam logic [8:0] RECIP_Q = 9'(RECIP_ONE / MOD_COLS);

  logic [SCHEME_W-1:0]  scheme_r;
  in_item_t             in_r;
  logic [INDEX_W-1:0]   iq_r, jq_r;
  logic [2:0]           ir_r, jr_r;
  logic [MODIX_W-1:0]   mr_r, mc_r;
  logic [LA_W-1:0]      laddr_r;
  logic [FLAT_W-1:0]    flat_r;
  logic [FLAT_W-1:0]    pflat_r;
  logic [MODIX_W-1:0]   pmr_r, pmc_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic                 out_valid_r;
  out_item_t            out_item_r;

  dm_t                  dm_i, dm_j, dm_v, dm_h;
  logic [6:0]           i7, j7, sum_v, sum_h;
  logic [FLAT_W-1:0]    rd_addr;
  logic                 par_last;

  // Scheme register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= SCH_NONE;
    end else if (cfg_we) begin
      scheme_r <= cfg_data;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  // Stage A: split row and column over the module grid
  assign dm_i = divmod_small(7'(in_r.row_index), DIV_P, RECIP_P);
  assign dm_j = divmod_small(7'(in_r.col_index), DIV_Q, RECIP_Q);

  always_ff @(posedge clk) begin
    iq_r <= dm_i.quot[INDEX_W-1:0];
    ir_r <= dm_i.rem;
    jq_r <= dm_j.quot[INDEX_W-1:0];
    jr_r <= dm_j.rem;
  end

  // Stage B: pick the skew of the selected scheme
  assign i7 = 7'(in_r.row_index);
  assign j7 = 7'(in_r.col_index);

  always_comb begin
    sum_v = i7;
    sum_h = j7;
    unique case (scheme_r)
      SCH_RECT_ROW: begin
        sum_v = i7 + 7'(jq_r);
      end
      SCH_RECT_COL: begin
        sum_h = 7'(iq_r) + j7;
      end
      SCH_ROW_COL: begin
        sum_v = i7 + 7'(jq_r);
        sum_h = 7'(iq_r) + j7;
      end
      SCH_RECT_TRECT: begin
        // transposed rectangles skew along the longer grid side
        if (MOD_ROWS < MOD_COLS) begin
          sum_h = i7 - 7'(ir_r) + j7;
        end else begin
          sum_v = i7 + j7 - 7'(jr_r);
        end
      end
      default: begin
        sum_v = i7;
        sum_h = j7;
      end
    endcase
  end

  assign dm_v = divmod_small(sum_v, DIV_P, RECIP_P);
  assign dm_h = divmod_small(sum_h, DIV_Q, RECIP_Q);

  always_ff @(posedge clk) begin
    mr_r    <= dm_v.rem;
    mc_r    <= dm_h.rem;
    laddr_r <= LA_W'(iq_r) * LA_W'(ROW_STRIDE) + LA_W'(jq_r);
  end

  // Stage C: flat memory address of the element
  always_ff @(posedge clk) begin
    flat_r <= (FLAT_W'(mr_r) * FLAT_W'(MOD_COLS) + FLAT_W'(mc_r)) * FLAT_W'(MODULE_DEPTH)
              + FLAT_W'(laddr_r);
  end

  // Walk the module grid row-major on a parallel read
  assign par_last = (pmr_r == MODIX_W'(MOD_ROWS - 1)) && (pmc_r == MODIX_W'(MOD_COLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.par_init) begin
      pmr_r   <= '0;
      pmc_r   <= '0;
      pflat_r <= FLAT_W'(in_r.slot);
    end else if (cmd.par_step) begin
      if (pmc_r == MODIX_W'(MOD_COLS - 1)) begin
        pmc_r <= '0;
        pmr_r <= pmr_r + MODIX_W'(1);
      end else begin
        pmc_r <= pmc_r + MODIX_W'(1);
      end
      pflat_r <= pflat_r + FLAT_W'(MODULE_DEPTH);
    end
  end

  // Word memory: one write or one registered read per cycle
  assign rd_addr = cmd.rd_par ? pflat_r : flat_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[flat_r] <= in_r.write_data;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Status back to the sequencer
  assign stat.op        = in_r.op;
  assign stat.scheme_ok = (scheme_r >= SCH_RECT) && (scheme_r <= SCH_RECT_TRECT);
  assign stat.slot_ok   = SCMP_W'(in_r.slot) < SCMP_W'(MODULE_DEPTH);
  assign stat.addr_ok   = ACMP_W'(laddr_r) < ACMP_W'(MODULE_DEPTH);
  assign stat.par_last  = par_last;

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.kind)
        EK_NOSCH: begin
          out_item_r <= '{read_data: '0, module_row: '0, module_col: '0,
                          status: ST_NO_SCHEME, last: 1'b1};
        end
        EK_RANGE: begin
          out_item_r <= '{read_data: '0, module_row: '0, module_col: '0,
                          status: ST_RANGE, last: 1'b1};
        end
        EK_WRITE: begin
          out_item_r <= '{read_data: '0, module_row: mr_r, module_col: mc_r,
                          status: ST_OK, last: 1'b1};
        end
        EK_READ: begin
          out_item_r <= '{read_data: rd_data_r, module_row: mr_r, module_col: mc_r,
                          status: ST_OK, last: 1'b1};
        end
        EK_PAR: begin
          out_item_r <= '{read_data: rd_data_r, module_row: pmr_r, module_col: pmc_r,
                          status: ST_OK, last: par_last};
        end
        default: begin
          out_item_r <= '{read_data: '0, module_row: '0, module_col: '0,
                          status: ST_RANGE, last: 1'b1};
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/polymorphic_register_file_access.sv =====
// ----------------------------------------------------------------------------
// polymorphic_register_file_access
// Matrix register file spread over a MOD_ROWS x MOD_COLS grid of word
// memories, with a selectable module-assignment scheme.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the word is taken at an edge where start
//   is high and busy is low. Each result shows on out_item for one cycle
//   with out_valid high; the receiver must take it then.
//   cfg_data loads the scheme register when cfg_valid is high (cfg_ready is
//   always high); write it only while busy is low and no result is pending.
//   Each result strobes the cycle after the sequencer issues it: a parallel
//   read alternates a memory read and a result strobe for each module, and
//   the last result of any word shows in the first cycle with busy low. A
//   read or write word passes through the two registered divide stages of
//   the module mapping, the flat address stage and the single-port word
//   memory, which on a parallel read serves the modules one at a time in
//   row-major order.
//   Reset clears the scheme to SCH_NONE and the sequencer to idle; the
//   memory contents are not cleared and read undefined until written.
// ----------------------------------------------------------------------------
module polymorphic_register_file_access #(
  parameter int MOD_ROWS     = pra_pkg::DEF_MOD_ROWS,
  parameter int MOD_COLS     = pra_pkg::DEF_MOD_COLS,
  parameter int MATRIX_COLS  = pra_pkg::DEF_MATRIX_COLS,
  parameter int MODULE_DEPTH = pra_pkg::DEF_MODULE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pra_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output pra_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pra_pkg::SCHEME_W-1:0]  cfg_data
);
  import pra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Scheme writes are always taken
  assign cfg_ready = 1'b1;

  pra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pra_dp #(
    .MOD_ROWS     (MOD_ROWS),
    .MOD_COLS     (MOD_COLS),
    .MATRIX_COLS  (MATRIX_COLS),
    .MODULE_DEPTH (MODULE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
